FILE: rtl/multi_channel_note_sequencer_unit_defines.svh
// assertion macros for the note sequencer checker
// no dependencies; included by the checker file
`ifndef MULTI_CHANNEL_NOTE_SEQUENCER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_NOTE_SEQUENCER_UNIT_DEFINES_SVH

// checked only outside reset
`define MSQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("note sequencer check failed");

// checked also while reset is applied
`define MSQ_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("note sequencer reset check failed");

`endif

FILE: rtl/msq_pkg.sv
// shared types and constants of the note sequencer
// no dependencies; imported by every module of the block
package msq_pkg;

	localparam int NOTE_DEPTH_DEF    = 256;
	localparam int CHANNEL_COUNT_DEF = 3;
	localparam int MAX_CHANNELS      = 3;
	localparam int QUEUE_DEPTH       = 4;

	localparam int COUNT_W  = 9;
	localparam int VOLUME_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_BASE = 3'd3;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_WRITE,
		KIND_RESTART
	} msq_kind_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  channel;
		logic [7:0]  slot;
		logic [15:0] note_frequency;
		logic [7:0]  note_duration;
	} msq_in_t;

	typedef struct packed {
		logic [1:0]  tone_channel;
		logic [15:0] tone_frequency;
		logic [7:0]  tone_volume;
		logic        last;
	} msq_out_t;

	typedef struct packed {
		msq_kind_t   kind;
		logic [1:0]  channel;
		logic [7:0]  slot;
		logic [15:0] note_frequency;
		logic [7:0]  note_duration;
	} msq_cmd_t;

	typedef struct packed {
		logic [15:0] freq;
		logic [7:0]  dur;
	} msq_note_t;

endpackage

FILE: rtl/msq_queue.sv
// command queue between front decode and back execution
// depends on msq_pkg
module msq_queue import msq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  msq_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output msq_cmd_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	msq_cmd_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: rtl/msq_front.sv
// input side: accepts items, decodes the operation and drops no-op items
// depends on msq_pkg
module msq_front import msq_pkg::*; #(
	parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
	parameter int NCH        = CHANNEL_COUNT_DEF
) (
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  msq_in_t  cmd_item,
	input  logic     queue_full,
	output logic     push,
	output msq_cmd_t push_cmd
);

	localparam int SLOT_CMP_W = ($clog2(NOTE_DEPTH + 1) > 9) ? $clog2(NOTE_DEPTH + 1) : 9;

	logic      keep;
	logic      ch_ok;
	logic      slot_ok;
	msq_kind_t kind;

	assign ch_ok   = (cmd_item.channel < 2'(NCH));
	assign slot_ok = (SLOT_CMP_W'(cmd_item.slot) < SLOT_CMP_W'(NOTE_DEPTH));

	always_comb begin
		keep = 1'b0;
		kind = KIND_TICK;
		unique case (cmd_item.operation)
			OP_TICK: begin
				keep = 1'b1;
				kind = KIND_TICK;
			end
			OP_WRITE: begin
				keep = ch_ok && slot_ok;
				kind = KIND_WRITE;
			end
			OP_RESTART: begin
				keep = ch_ok;
				kind = KIND_RESTART;
			end
			default: begin
				keep = 1'b0;
				kind = KIND_TICK;
			end
		endcase
	end

	assign cmd_stall = queue_full;
	assign push      = cmd_valid && !queue_full && keep;

	assign push_cmd = '{
		kind:           kind,
		channel:        cmd_item.channel,
		slot:           cmd_item.slot,
		note_frequency: cmd_item.note_frequency,
		note_duration:  cmd_item.note_duration
	};

endmodule

FILE: rtl/msq_back.sv
// execution side: note store, per-channel position and wait counters, result register
// depends on msq_pkg
module msq_back import msq_pkg::*; #(
	parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
	parameter int NCH        = CHANNEL_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  msq_cmd_t            head,
	output logic                pop,
	input  logic [COUNT_W-1:0]  note_count [NCH],
	input  logic [VOLUME_W-1:0] volume [NCH],
	output logic                tone_valid,
	input  logic                tone_stall,
	output msq_out_t            tone_item
);

	localparam int CHW       = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PW        = $clog2(NOTE_DEPTH + 1);
	localparam int SW        = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
	localparam int CMPW      = (PW > COUNT_W) ? PW : COUNT_W;
	localparam int MEM_DEPTH = NCH * NOTE_DEPTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	msq_note_t note_mem [MEM_DEPTH];

	logic [PW-1:0]  pos_q   [NCH];
	logic [7:0]     ticks_q [NCH];
	logic [CHW-1:0] chan_q;

	logic                s2_valid_q;
	logic [CHW-1:0]      s2_ch_s2;
	logic                s2_play_s2;
	logic [VOLUME_W-1:0] s2_vol_s2;
	logic                s2_last_s2;
	msq_note_t           rd_s2;

	logic     out_valid_q;
	msq_out_t out_q;

	logic [7:0] eff_ticks [NCH];
	logic       play_ok   [NCH];
	logic       last_c;
	logic       s2_move;
	logic       issue;
	logic       is_tick;
	logic       tick_wait;
	logic       tick_emit;
	logic       mem_we;
	logic       mem_re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [PW-1:0] pos_c;

	always_comb begin
		for (int j = 0; j < NCH; j++) begin
			eff_ticks[j] = (s2_valid_q && s2_play_s2 && (s2_ch_s2 == CHW'(j))) ?
				rd_s2.dur : ticks_q[j];
			play_ok[j] = (CMPW'(pos_q[j]) < CMPW'(note_count[j])) &&
				(pos_q[j] < PW'(NOTE_DEPTH));
		end
	end

	// a later channel of this tick that is not waiting will still emit
	always_comb begin
		last_c = 1'b1;
		for (int j = 0; j < NCH; j++) begin
			if ((CHW'(j) > chan_q) && (eff_ticks[j] == 8'd0))
				last_c = 1'b0;
		end
	end

	assign s2_move   = s2_valid_q && (!out_valid_q || !tone_stall);
	assign issue     = head_valid && (!s2_valid_q || s2_move);
	assign is_tick   = (head.kind == KIND_TICK);
	assign tick_wait = (eff_ticks[chan_q] != 8'd0);
	assign tick_emit = is_tick && !tick_wait;
	assign pos_c     = pos_q[chan_q];

	assign mem_we = issue && (head.kind == KIND_WRITE);
	assign mem_re = issue && tick_emit && play_ok[chan_q];
	assign waddr  = AW'(head.channel) * AW'(NOTE_DEPTH) + AW'(SW'(head.slot));
	assign raddr  = AW'(chan_q) * AW'(NOTE_DEPTH) + AW'(pos_c[SW-1:0]);

	assign pop = issue && (!is_tick || (chan_q == CHW'(NCH - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NCH; j++) begin
				pos_q[j]   <= '0;
				ticks_q[j] <= '0;
			end
			chan_q      <= '0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a restart or a decrement overrides the duration of a note leaving the read stage
			for (int j = 0; j < NCH; j++) begin
				if (issue && (head.kind == KIND_RESTART) && (CHW'(head.channel) == CHW'(j)))
					ticks_q[j] <= '0;
				else if (issue && is_tick && tick_wait && (chan_q == CHW'(j)))
					ticks_q[j] <= eff_ticks[j] - 8'd1;
				else if (s2_move && s2_play_s2 && (s2_ch_s2 == CHW'(j)))
					ticks_q[j] <= rd_s2.dur;
			end
			if (issue) begin
				unique case (head.kind)
					KIND_RESTART: begin
						pos_q[CHW'(head.channel)] <= '0;
					end
					KIND_TICK: begin
						if (!tick_wait && play_ok[chan_q])
							pos_q[chan_q] <= pos_c + 1'b1;
						if (chan_q == CHW'(NCH - 1))
							chan_q <= '0;
						else
							chan_q <= chan_q + 1'b1;
					end
					KIND_WRITE: begin
					end
					default: begin
					end
				endcase
			end
			if (issue && tick_emit)
				s2_valid_q <= 1'b1;
			else if (s2_move)
				s2_valid_q <= 1'b0;
			if (s2_move)
				out_valid_q <= 1'b1;
			else if (!tone_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && tick_emit) begin
			s2_ch_s2   <= chan_q;
			s2_play_s2 <= play_ok[chan_q];
			s2_vol_s2  <= volume[chan_q];
			s2_last_s2 <= last_c;
		end
		if (s2_move) begin
			out_q <= '{
				tone_channel:   2'(s2_ch_s2),
				tone_frequency: s2_play_s2 ? rd_s2.freq : 16'd0,
				tone_volume:    s2_play_s2 ? s2_vol_s2 : '0,
				last:           s2_last_s2
			};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			note_mem[waddr] <= '{freq: head.note_frequency, dur: head.note_duration};
		if (mem_re)
			rd_s2 <= note_mem[raddr];
	end

	assign tone_valid = out_valid_q;
	assign tone_item  = out_q;

endmodule

FILE: rtl/multi_channel_note_sequencer_unit.sv
// Three-channel note sequencer. Items on the cmd channel are ticks, note-store writes
// and channel restarts; they pass a four-entry queue to an execution unit that visits
// one channel per clock while the result path is not stalled, through a single read
// port of the note store, so a tick visits every driven channel (three by default).
// Items with the unused operation code or an out-of-range channel or slot are
// accepted and dropped without using execution cycles. Results leave one per cycle
// unless stalled, via read and result registers, with last marking each tick's end.
// Note-store entries read before being written give undefined tones.
// top level; depends on msq_pkg, msq_front, msq_queue, msq_back
module multi_channel_note_sequencer_unit import msq_pkg::*; #(
	parameter int NOTE_DEPTH    = NOTE_DEPTH_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  msq_in_t              cmd_item,
	output logic                 tone_valid,
	input  logic                 tone_stall,
	output msq_out_t             tone_item
);

	localparam int NCH = (CHANNEL_COUNT < MAX_CHANNELS) ? CHANNEL_COUNT : MAX_CHANNELS;

	logic [COUNT_W-1:0]  note_count_q [NCH];
	logic [VOLUME_W-1:0] volume_q     [NCH];

	logic     queue_full;
	logic     push;
	msq_cmd_t push_cmd;
	logic     pop;
	logic     head_valid;
	msq_cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				note_count_q[i] <= '0;
				volume_q[i]     <= '0;
			end
		end else if (cfg_write) begin
			for (int i = 0; i < NCH; i++) begin
				if (cfg_index == CFG_COUNT_BASE + CFG_IDX_W'(i))
					note_count_q[i] <= cfg_data;
				if (cfg_index == CFG_VOLUME_BASE + CFG_IDX_W'(i))
					volume_q[i] <= cfg_data[VOLUME_W-1:0];
			end
		end
	end

	msq_front #(
		.NOTE_DEPTH (NOTE_DEPTH),
		.NCH        (NCH)
	) u_front (
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_item   (cmd_item),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	msq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	msq_back #(
		.NOTE_DEPTH (NOTE_DEPTH),
		.NCH        (NCH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.note_count (note_count_q),
		.volume     (volume_q),
		.tone_valid (tone_valid),
		.tone_stall (tone_stall),
		.tone_item  (tone_item)
	);

endmodule

FILE: rtl/msq_checker.sv
// port-level checks of the note sequencer result channel, bound to the top level
// depends on msq_pkg and multi_channel_note_sequencer_unit_defines.svh
`include "multi_channel_note_sequencer_unit_defines.svh"

module msq_checker import msq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     tone_valid,
	input logic     tone_stall,
	input msq_out_t tone_item
);

	`MSQ_ASSERT_RST(a_no_tone_in_reset, !arst_n |=> !tone_valid)

	`MSQ_ASSERT(a_stalled_tone_holds,
		tone_valid && tone_stall |=> tone_valid && $stable(tone_item))

	`MSQ_ASSERT(a_channel_in_range,
		tone_valid |-> tone_item.tone_channel < 2'(MAX_CHANNELS))

	// within one tick the channels come out in rising order
	`MSQ_ASSERT(a_tick_order,
		tone_valid && !tone_stall && !tone_item.last |=>
			!tone_valid || (tone_item.tone_channel > $past(tone_item.tone_channel)))

endmodule

bind multi_channel_note_sequencer_unit msq_checker u_msq_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for multi_channel_note_sequencer_unit: a directed table, then random phases
// with stalls on both sides, tones checked against an in-file sequencer predictor
// depends on msq_pkg and the block's rtl
module testbench;
	import msq_pkg::*;

	localparam logic [1:0]           OP_UNUSED     = 2'd3;
	localparam logic [1:0]           NO_CHANNEL    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 27;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 80;
	localparam int IDLE_LIMIT    = 1000;

	typedef struct packed {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [COUNT_W-1:0]   data;
		msq_in_t              it;
		bit                   typed;
		logic [1:0]           n;
		msq_out_t [2:0]       want;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0]   cfg_data = '0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	msq_in_t              cmd_item = '0;
	logic                 tone_valid;
	logic                 tone_stall = 1'b0;
	msq_out_t             tone_item;

	// sequencer state as the block should hold it
	msq_note_t          notes [3][256];
	bit                 written [3][256];
	logic [COUNT_W-1:0] pos [3];
	logic [7:0]         hold [3];
	logic [COUNT_W-1:0] count [3];
	logic [VOLUME_W-1:0] vol [3];

	msq_out_t tones_due [$];
	int mismatches = 0;
	int tones_checked = 0;
	int items_sent = 0;
	int reg_writes = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit calm = 1'b0;

	multi_channel_note_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.tone_valid(tone_valid),
		.tone_stall(tone_stall),
		.tone_item(tone_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic msq_in_t make_cmd(input logic [1:0] op, input logic [1:0] ch,
		input logic [7:0] slot, input logic [15:0] f, input logic [7:0] d);
		msq_in_t it;
		it.operation      = op;
		it.channel        = ch;
		it.slot           = slot;
		it.note_frequency = f;
		it.note_duration  = d;
		return it;
	endfunction

	function automatic msq_out_t make_tone(input logic [1:0] ch, input logic [15:0] f,
		input logic [7:0] v, input logic l);
		msq_out_t t;
		t.tone_channel   = ch;
		t.tone_frequency = f;
		t.tone_volume    = v;
		t.last           = l;
		return t;
	endfunction

	function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [COUNT_W-1:0] data);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic step_row_t row_pred(input msq_in_t it);
		step_row_t r;
		r = '0;
		r.it = it;
		return r;
	endfunction

	function automatic step_row_t row_want(input msq_in_t it, input logic [1:0] n,
		input msq_out_t w0, input msq_out_t w1, input msq_out_t w2);
		step_row_t r;
		r = '0;
		r.it      = it;
		r.typed   = 1'b1;
		r.n       = n;
		r.want[0] = w0;
		r.want[1] = w1;
		r.want[2] = w2;
		return r;
	endfunction

	function automatic logic [COUNT_W-1:0] limit_of(input int c);
		return (count[c] > 9'd256) ? 9'd256 : count[c];
	endfunction

	function automatic logic [7:0] short_dur();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
	endfunction

	// advances the sequencer by one item; queues its tones when keep is set
	function automatic void step_sequencer(input msq_in_t it, input bit keep);
		msq_out_t res [$];
		msq_out_t r;
		case (it.operation)
			OP_WRITE: begin
				if (it.channel != NO_CHANNEL) begin
					notes[it.channel][it.slot].freq = it.note_frequency;
					notes[it.channel][it.slot].dur  = it.note_duration;
					written[it.channel][it.slot]    = 1'b1;
				end
			end
			OP_RESTART: begin
				if (it.channel != NO_CHANNEL) begin
					pos[it.channel]  = '0;
					hold[it.channel] = '0;
				end
			end
			OP_TICK: begin
				for (int c = 0; c < MAX_CHANNELS; c++) begin
					if (hold[c] != 8'd0) begin
						hold[c]--;
					end else begin
						r = '0;
						r.tone_channel = 2'(c);
						if (pos[c] < limit_of(c)) begin
							r.tone_frequency = notes[c][pos[c][7:0]].freq;
							r.tone_volume    = vol[c];
							hold[c]          = notes[c][pos[c][7:0]].dur;
							pos[c]++;
						end
						res.push_back(r);
					end
				end
			end
			default: ;
		endcase
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
		if (keep)
			foreach (res[i]) tones_due.push_back(res[i]);
	endfunction

	task automatic offer(input msq_in_t it);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic play_item(input msq_in_t it);
		offer(it);
		step_sequencer(it, 1'b1);
	endtask

	// fills each note a channel is about to play that is unwritten (every such note when fresh), then ticks
	task automatic issue_tick(input bit fresh);
		for (int c = 0; c < MAX_CHANNELS; c++)
			if (hold[c] == 8'd0 && pos[c] < limit_of(c) && (fresh || !written[c][pos[c][7:0]]))
				play_item(make_cmd(OP_WRITE, 2'(c), pos[c][7:0], 16'($urandom),
					fresh ? 8'd0 : short_dur()));
		play_item(make_cmd(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom)));
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (tones_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		reg_writes++;
		if (idx < CFG_VOLUME_BASE)
			count[idx - CFG_COUNT_BASE] = data;
		else if (idx < CFG_VOLUME_BASE + 3'd3)
			vol[idx - CFG_VOLUME_BASE] = data[VOLUME_W-1:0];
	endtask

	task automatic flag(input string what, input msq_out_t want, input msq_out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected ch %0d freq %h vol %h last %b, got ch %0d freq %h vol %h last %b",
				what, want.tone_channel, want.tone_frequency, want.tone_volume, want.last,
				got.tone_channel, got.tone_frequency, got.tone_volume, got.last);
	endtask

	// tone receiver: short random stalls, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold) begin
				tone_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				tone_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				tone_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				tone_stall <= 1'b0;
			end else begin
				tone_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : tone_check
		msq_out_t want;
		if (arst_n && tone_valid && !tone_stall) begin
			tones_checked++;
			if (tones_due.size() == 0) begin
				flag("tone with none expected", '0, tone_item);
			end else begin
				want = tones_due.pop_front();
				if (tone_item.tone_channel !== want.tone_channel
					|| tone_item.tone_frequency !== want.tone_frequency
					|| tone_item.tone_volume !== want.tone_volume
					|| tone_item.last !== want.last)
					flag("tone differs", want, tone_item);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (tone_valid && !tone_stall) || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		step_row_t plan [$];
		logic [COUNT_W-1:0] lens [3];
		logic [VOLUME_W-1:0] gains [3];
		int pick;

		foreach (pos[c]) begin
			pos[c]   = '0;
			hold[c]  = '0;
			count[c] = '0;
			vol[c]   = '0;
		end

		// after reset every channel is silent
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd0, 8'h00, 16'h0000, 8'h00), 2'd3,
			make_tone(2'd0, 16'h0, 8'h0, 1'b0), make_tone(2'd1, 16'h0, 8'h0, 1'b0),
			make_tone(2'd2, 16'h0, 8'h0, 1'b1)));
		plan.push_back(row_want(make_cmd(OP_UNUSED, NO_CHANNEL, 8'hff, 16'hffff, 8'hff), 2'd0,
			'0, '0, '0));
		plan.push_back(row_want(make_cmd(OP_WRITE, NO_CHANNEL, 8'hff, 16'hffff, 8'hff), 2'd0,
			'0, '0, '0));
		plan.push_back(row_want(make_cmd(OP_RESTART, NO_CHANNEL, 8'h00, 16'h0, 8'h00), 2'd0,
			'0, '0, '0));
		plan.push_back(row_cfg(CFG_COUNT_BASE, 9'd2));
		plan.push_back(row_cfg(CFG_COUNT_BASE + 3'd1, 9'd1));
		plan.push_back(row_cfg(CFG_COUNT_BASE + 3'd2, 9'd2));
		plan.push_back(row_cfg(CFG_VOLUME_BASE, 9'd255));
		plan.push_back(row_cfg(CFG_VOLUME_BASE + 3'd1, 9'd0));
		plan.push_back(row_cfg(CFG_VOLUME_BASE + 3'd2, 9'd128));
		plan.push_back(row_cfg(CFG_UNUSED_LO, 9'h1ff));
		plan.push_back(row_cfg(CFG_UNUSED_HI, 9'h1ff));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd0, 8'h00, 16'hffff, 8'h01)));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd0, 8'h01, 16'h0001, 8'hff)));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd1, 8'h00, 16'h8000, 8'h01)));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd2, 8'h00, 16'h1234, 8'h01)));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd2, 8'h01, 16'h0000, 8'h00)));
		plan.push_back(row_pred(make_cmd(OP_WRITE, 2'd2, 8'hff, 16'habcd, 8'haa)));
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd0, 8'h00, 16'h0, 8'h00), 2'd3,
			make_tone(2'd0, 16'hffff, 8'hff, 1'b0), make_tone(2'd1, 16'h8000, 8'h00, 1'b0),
			make_tone(2'd2, 16'h1234, 8'h80, 1'b1)));
		// every channel waiting
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd3, 8'hff, 16'hffff, 8'hff), 2'd0,
			'0, '0, '0));
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd0, 8'h00, 16'h0, 8'h00), 2'd3,
			make_tone(2'd0, 16'h0001, 8'hff, 1'b0), make_tone(2'd1, 16'h0, 8'h0, 1'b0),
			make_tone(2'd2, 16'h0000, 8'h80, 1'b1)));
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd0, 8'h00, 16'h0, 8'h00), 2'd2,
			make_tone(2'd1, 16'h0, 8'h0, 1'b0), make_tone(2'd2, 16'h0, 8'h0, 1'b1), '0));
		plan.push_back(row_want(make_cmd(OP_RESTART, 2'd0, 8'h00, 16'h0, 8'h00), 2'd0,
			'0, '0, '0));
		plan.push_back(row_want(make_cmd(OP_TICK, 2'd0, 8'h00, 16'h0, 8'h00), 2'd3,
			make_tone(2'd0, 16'hffff, 8'hff, 1'b0), make_tone(2'd1, 16'h0, 8'h0, 1'b0),
			make_tone(2'd2, 16'h0, 8'h0, 1'b1)));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				set_reg(plan[i].idx, plan[i].data);
			end else begin
				offer(plan[i].it);
				step_sequencer(plan[i].it, !plan[i].typed);
				if (plan[i].typed)
					for (int k = 0; k < plan[i].n; k++) tones_due.push_back(plan[i].want[k]);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					lens  = '{9'd5, 9'd3, 9'd8};
					gains = '{8'd200, 8'd17, 8'd255};
				end
				1: begin
					lens  = '{9'd256, 9'd0, 9'd1};
					gains = '{8'd0, 8'd255, 8'd100};
				end
				2: begin
					lens  = '{9'd511, 9'd300, 9'd4};
					foreach (gains[c]) gains[c] = 8'($urandom);
				end
				default: begin
					foreach (lens[c]) begin
						lens[c]  = 9'($urandom_range(0, 24));
						gains[c] = 8'($urandom);
					end
				end
			endcase
			settle();
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				set_reg(CFG_COUNT_BASE + 3'(c), lens[c]);
				set_reg(CFG_VOLUME_BASE + 3'(c), {1'b0, gains[c]});
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 10)
					long_hold = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 45)
					issue_tick(1'b0);
				else if (pick < 80)
					play_item(make_cmd(OP_WRITE, 2'($urandom_range(0, 2)),
						($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
						16'($urandom), short_dur()));
				else if (pick < 88)
					play_item(make_cmd(OP_RESTART, 2'($urandom_range(0, 2)), 8'($urandom),
						16'($urandom), 8'($urandom)));
				else if (pick < 94)
					play_item(make_cmd(OP_UNUSED, 2'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom)));
				else
					play_item(make_cmd(2'($urandom_range(OP_WRITE, OP_RESTART)), NO_CHANNEL,
						8'($urandom), 16'($urandom), 8'($urandom)));
			end
		end

		// no idling at the end: channel 0 plays fresh notes from a list longer than the store
		calm = 1'b1;
		settle();
		lens = '{9'd300, 9'd0, 9'd0};
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			set_reg(CFG_COUNT_BASE + 3'(c), lens[c]);
			set_reg(CFG_VOLUME_BASE + 3'(c), 9'($urandom_range(0, 255)));
		end
		play_item(make_cmd(OP_RESTART, 2'd0, 8'($urandom), 16'($urandom), 8'($urandom)));
		repeat (8) issue_tick(1'b1);

		settle();
		$display("sent %0d commands and %0d register writes over %0d register settings",
			items_sent, reg_writes, PHASES + 2);
		$display("compared %0d tones, %0d mismatches", tones_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
